/* design/triangle_face_normal_top_assert.svh */
// assertion macros for the face normal block
// used by triangle_face_normal_top.sv, expects clk and rst_n in scope
`ifndef TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH

// condition that holds at every edge outside reset
`define TFN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tfn_pkg.sv */
// types and constants of the face normal block
// no dependencies; imported by every module of the block
`default_nettype none

package tfn_pkg;

  localparam int AXES    = 3;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int CROSS_W = 35;
  localparam int MAG_W   = 24;
  localparam int SHIFT_W = 4;
  localparam int SQ_W    = 48;
  localparam int SUM_W   = 50;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int NUM_W   = 46;
  localparam int QUO_W   = 15;
  localparam int NORM_W  = 16;
  localparam int SLOT_W  = 17;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TRI  = 1'b1;

  localparam logic [QUO_W-1:0] NORM_ONE = 15'd16384;

  typedef struct packed {
    logic                    command;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } tfn_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_a;
    logic [IDX_W-1:0]         out_b;
    logic [IDX_W-1:0]         out_c;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
  } tfn_out_t;

  // queue entry: item plus range classification
  typedef struct packed {
    tfn_in_t         data;
    logic            load_ok;
    logic [AXES-1:0] corner_ok;
  } tfn_item_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } tfn_fifo_st_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_a;
    logic [IDX_W-1:0] out_b;
    logic [IDX_W-1:0] out_c;
  } tfn_tag_t;

  typedef struct packed {
    tfn_tag_t                   tag;
    logic [AXES-1:0][MAG_W-1:0] mag;
    logic [AXES-1:0]            neg;
    logic                       degen;
  } tfn_side_t;

  typedef struct packed {
    logic              valid;
    tfn_side_t         side;
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } tfn_sqrt_t;

  typedef struct packed {
    logic                       valid;
    tfn_side_t                  side;
    logic [ROOT_W-1:0]          len;
    logic [AXES-1:0][NUM_W-1:0] rem;
    logic [AXES-1:0][QUO_W-1:0] quo;
  } tfn_div_t;

endpackage

`default_nettype wire

/* design/triangle_face_normal_top.sv */
// face normal block: vertex position loads and triangle normal requests
// in one stream, with a registered result channel
// input channel in_valid/in_stall/in_data: command 0 loads a vertex slot,
// command 1 asks for the unit normal of triangle (a, b, c); loads give no
// transaction on the output, triangles give exactly one, in order
// output channel out_valid/out_stall/out_data: corner slots echoed, normal
// in signed Q1.14, degenerate set with a zero normal when the cross is zero
// throughput: one item per cycle while out_stall does not hold the back
// end; a 4-entry input queue sits in front of a fully pipelined back end
// (store read, cross product, 31-stage square root, 15-stage dividers)
// out_stall holds the whole back end while out_valid is set; the queue
// keeps taking items until it holds four, then in_stall rises
// reset clears the queue and all valid bits; the vertex store is not
// cleared, so a triangle must only name slots that a load has written
`default_nettype none

module triangle_face_normal_top import tfn_pkg::*; #(
  parameter int VERTEX_SLOTS = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire tfn_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output tfn_out_t     out_data
);

  `include "triangle_face_normal_top_assert.svh"

  logic         adv;
  logic         pop;
  tfn_item_t    head;
  tfn_fifo_st_t fst;
  tfn_sqrt_t    rad, root;
  tfn_div_t     quot;

  logic                     out_valid_r;
  tfn_out_t                 out_data_r, out_data_nxt;
  logic [QUO_W-1:0]         q [AXES];
  logic signed [NORM_W-1:0] nv [AXES];

  assign adv = !out_valid_r || !out_stall;

  tfn_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .head     (head),
    .status   (fst)
  );

  tfn_back #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .fst   (fst),
    .head  (head),
    .pop   (pop),
    .rad   (rad)
  );

  tfn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .din   (rad),
    .dout  (root)
  );

  tfn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .din   (root),
    .dout  (quot)
  );

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      q[k]  = (quot.quo[k] > NORM_ONE) ? NORM_ONE : quot.quo[k];
      nv[k] = quot.side.degen ? '0 :
              (quot.side.neg[k] ? -NORM_W'(q[k]) : NORM_W'(q[k]));
    end
    out_data_nxt.out_a      = quot.side.tag.out_a;
    out_data_nxt.out_b      = quot.side.tag.out_b;
    out_data_nxt.out_c      = quot.side.tag.out_c;
    out_data_nxt.norm_x     = nv[0];
    out_data_nxt.norm_y     = nv[1];
    out_data_nxt.norm_z     = nv[2];
    out_data_nxt.degenerate = quot.side.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= quot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TFN_ASSERT_IMPL(a_degen_zero, out_valid && out_data.degenerate, out_data.norm_x == '0 && out_data.norm_y == '0 && out_data.norm_z == '0, "degenerate result with nonzero normal")
  `TFN_ASSERT_ALWAYS(a_norm_range, !out_valid || ($signed(out_data.norm_x) <= 16'sd16384 && $signed(out_data.norm_x) >= -16'sd16384 && $signed(out_data.norm_y) <= 16'sd16384 && $signed(out_data.norm_y) >= -16'sd16384 && $signed(out_data.norm_z) <= 16'sd16384 && $signed(out_data.norm_z) >= -16'sd16384), "normal component out of range")
  `TFN_ASSERT_NEXT(a_queue_fill, in_valid && !in_stall && !pop, fst.count == $past(fst.count) + 3'd1, "queue did not grow on an unmatched push")

endmodule

`default_nettype wire

/* design/tfn_front.sv */
// front end: classifies items and queues them in order
// depends on tfn_pkg
`default_nettype none

module tfn_front import tfn_pkg::*; #(
  parameter int VERTEX_SLOTS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire tfn_in_t      in_data,
  input  wire logic         pop,
  output tfn_item_t         head,
  output tfn_fifo_st_t      status
);

  localparam logic [SLOT_W-1:0] SLOTS = SLOT_W'(VERTEX_SLOTS);

  tfn_item_t        q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  tfn_item_t        item;

  assign in_stall = (count_r == CNT_W'(FIFO_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    item.data         = in_data;
    item.load_ok      = SLOT_W'(in_data.vertex_index) < SLOTS;
    item.corner_ok[0] = SLOT_W'(in_data.corner_a) < SLOTS;
    item.corner_ok[1] = SLOT_W'(in_data.corner_b) < SLOTS;
    item.corner_ok[2] = SLOT_W'(in_data.corner_c) < SLOTS;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign head         = q_r[rd_ptr_r];
  assign status.valid = (count_r != '0);
  assign status.count = count_r;

endmodule

`default_nettype wire

/* design/tfn_back.sv */
// back end: vertex store, edges, cross product, scaling and squared length
// depends on tfn_pkg; feeds tfn_sqrt
`default_nettype none

module tfn_back import tfn_pkg::*; #(
  parameter int VERTEX_SLOTS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         adv,
  input  wire tfn_fifo_st_t fst,
  input  wire tfn_item_t    head,
  output logic              pop,
  output tfn_sqrt_t         rad
);

  localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

  typedef logic [AXES-1:0][POS_W-1:0] pos3_t;

  // one copy per corner so each triangle reads three slots at once
  pos3_t mem_a [VERTEX_SLOTS];
  pos3_t mem_b [VERTEX_SLOTS];
  pos3_t mem_c [VERTEX_SLOTS];

  logic [SLOT_W-1:0] wi_x, ai_x, bi_x, ci_x;
  logic [AW-1:0]     wa, aa, ab, ac;
  pos3_t             wpos;
  logic              do_load, do_tri;

  assign pop     = adv && fst.valid;
  assign do_load = pop && (head.data.command == CMD_LOAD) && head.load_ok;
  assign do_tri  = pop && (head.data.command == CMD_TRI);
  assign wi_x    = SLOT_W'(head.data.vertex_index);
  assign ai_x    = SLOT_W'(head.data.corner_a);
  assign bi_x    = SLOT_W'(head.data.corner_b);
  assign ci_x    = SLOT_W'(head.data.corner_c);
  assign wa      = wi_x[AW-1:0];
  assign aa      = ai_x[AW-1:0];
  assign ab      = bi_x[AW-1:0];
  assign ac      = ci_x[AW-1:0];
  assign wpos    = {head.data.pos_z, head.data.pos_y, head.data.pos_x};

  // stage 1: store read
  pos3_t           ra_r, rb_r, rc_r;
  logic            v1_r;
  tfn_tag_t        tag1_r;
  logic [AXES-1:0] ok1_r;

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem_a[wa] <= wpos;
      mem_b[wa] <= wpos;
      mem_c[wa] <= wpos;
    end
    if (adv) begin
      ra_r <= mem_a[aa];
      rb_r <= mem_b[ab];
      rc_r <= mem_c[ac];
    end
  end

  // stage 2: edges
  logic signed [EDGE_W-1:0] e1_nxt [AXES];
  logic signed [EDGE_W-1:0] e2_nxt [AXES];
  logic signed [EDGE_W-1:0] e1_r [AXES];
  logic signed [EDGE_W-1:0] e2_r [AXES];
  pos3_t                    pa, pb, pc;
  logic                     v2_r;
  tfn_tag_t                 tag2_r;

  always_comb begin
    pa = ok1_r[0] ? ra_r : '0;
    pb = ok1_r[1] ? rb_r : '0;
    pc = ok1_r[2] ? rc_r : '0;
    for (int k = 0; k < AXES; k++) begin
      e1_nxt[k] = EDGE_W'($signed(pc[k])) - EDGE_W'($signed(pa[k]));
      e2_nxt[k] = EDGE_W'($signed(pb[k])) - EDGE_W'($signed(pa[k]));
    end
  end

  // stage 3: six products
  logic signed [PROD_W-1:0] p_nxt [2*AXES];
  logic signed [PROD_W-1:0] p_r [2*AXES];
  logic                     v3_r;
  tfn_tag_t                 tag3_r;

  always_comb begin
    p_nxt[0] = e1_r[1] * e2_r[2];
    p_nxt[1] = e1_r[2] * e2_r[1];
    p_nxt[2] = e1_r[2] * e2_r[0];
    p_nxt[3] = e1_r[0] * e2_r[2];
    p_nxt[4] = e1_r[0] * e2_r[1];
    p_nxt[5] = e1_r[1] * e2_r[0];
  end

  // stage 4: cross components as sign and magnitude
  logic signed [CROSS_W-1:0] cr [AXES];
  logic [CROSS_W-1:0]        m4_nxt [AXES];
  logic [CROSS_W-1:0]        m4_r [AXES];
  logic [AXES-1:0]           neg4_nxt, neg4_r;
  logic                      v4_r;
  tfn_tag_t                  tag4_r;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      cr[k]       = CROSS_W'(p_r[2*k]) - CROSS_W'(p_r[2*k+1]);
      neg4_nxt[k] = cr[k][CROSS_W-1];
      m4_nxt[k]   = neg4_nxt[k] ? CROSS_W'(-cr[k]) : CROSS_W'(cr[k]);
    end
  end

  // stage 5: common right shift so the largest fits in MAG_W bits
  logic [CROSS_W-1:0] mor;
  logic [SHIFT_W-1:0] sh;
  logic [CROSS_W-1:0] shifted [AXES];
  logic [MAG_W-1:0]   m5_nxt [AXES];
  logic [MAG_W-1:0]   m5_r [AXES];
  logic [AXES-1:0]    neg5_r;
  logic               degen5_r;
  logic               v5_r;
  tfn_tag_t           tag5_r;

  always_comb begin
    mor = m4_r[0] | m4_r[1] | m4_r[2];
    sh  = '0;
    // highest set bit of the or equals that of the max
    for (int b = MAG_W; b < CROSS_W; b++) begin
      if (mor[b]) begin
        sh = SHIFT_W'(b - MAG_W + 1);
      end
    end
    for (int k = 0; k < AXES; k++) begin
      shifted[k] = m4_r[k] >> sh;
      m5_nxt[k]  = shifted[k][MAG_W-1:0];
    end
  end

  // stage 6: squares
  logic [SQ_W-1:0] sq_r [AXES];
  logic [MAG_W-1:0] m6_r [AXES];
  logic [AXES-1:0]  neg6_r;
  logic             degen6_r;
  logic             v6_r;
  tfn_tag_t         tag6_r;

  // stage 7: radicand out
  logic [SUM_W-1:0] sum;
  logic             v7_r;
  tfn_side_t        side7_r;
  logic [RAD_W-1:0] rem7_r;

  assign sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= do_tri;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= '{out_a: head.data.corner_a, out_b: head.data.corner_b,
                  out_c: head.data.corner_c};
      ok1_r  <= head.corner_ok;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
      tag6_r <= tag5_r;
      for (int k = 0; k < AXES; k++) begin
        e1_r[k] <= e1_nxt[k];
        e2_r[k] <= e2_nxt[k];
        m4_r[k] <= m4_nxt[k];
        m5_r[k] <= m5_nxt[k];
        sq_r[k] <= m5_r[k] * m5_r[k];
        m6_r[k] <= m5_r[k];
      end
      for (int k = 0; k < 2*AXES; k++) begin
        p_r[k] <= p_nxt[k];
      end
      neg4_r   <= neg4_nxt;
      neg5_r   <= neg4_r;
      degen5_r <= (mor == '0);
      neg6_r   <= neg5_r;
      degen6_r <= degen5_r;
      side7_r.tag   <= tag6_r;
      side7_r.neg   <= neg6_r;
      side7_r.degen <= degen6_r;
      for (int k = 0; k < AXES; k++) begin
        side7_r.mag[k] <= m6_r[k];
      end
      rem7_r <= RAD_W'(sum) << 12;
    end
  end

  assign rad = '{valid: v7_r, side: side7_r, rem: rem7_r, root: '0};

endmodule

`default_nettype wire

/* design/tfn_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on tfn_pkg; fed by tfn_back, feeds tfn_div
`default_nettype none

module tfn_sqrt import tfn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire tfn_sqrt_t din,
  output tfn_sqrt_t      dout
);

  localparam int TW = RAD_W + 2;

  tfn_sqrt_t st [ROOT_W+1];

  assign st[0] = din;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int B = ROOT_W - 1 - i;

    logic [TW-1:0] trial;
    tfn_sqrt_t     stage_nxt;
    tfn_sqrt_t     stage_r;

    // rem holds x - root^2; try setting root bit B
    always_comb begin
      trial     = (TW'(st[i].root) << (B + 1)) + (TW'(1) << (2 * B));
      stage_nxt = st[i];
      if (TW'(st[i].rem) >= trial) begin
        stage_nxt.rem  = st[i].rem - RAD_W'(trial);
        stage_nxt.root = st[i].root | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (adv) begin
        stage_r <= stage_nxt;
      end
    end

    assign st[i+1] = stage_r;
  end

  assign dout = st[ROOT_W];

endmodule

`default_nettype wire

/* design/tfn_div.sv */
// rounding numerators and three pipelined restoring dividers
// depends on tfn_pkg; fed by tfn_sqrt
`default_nettype none

module tfn_div import tfn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire tfn_sqrt_t din,
  output tfn_div_t       dout
);

  tfn_div_t st [QUO_W+1];
  tfn_div_t num_nxt;
  tfn_div_t num_r;

  // (mag << 20) + len / 2, divided by len below
  always_comb begin
    num_nxt.valid = din.valid;
    num_nxt.side  = din.side;
    num_nxt.len   = din.root;
    for (int k = 0; k < AXES; k++) begin
      num_nxt.rem[k] = (NUM_W'(din.side.mag[k]) << 20) + NUM_W'(din.root >> 1);
      num_nxt.quo[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r.valid <= 1'b0;
    end else if (adv) begin
      num_r <= num_nxt;
    end
  end

  assign st[0] = num_r;

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int B = QUO_W - 1 - i;

    logic [NUM_W-1:0] dvs;
    tfn_div_t         stage_nxt;
    tfn_div_t         stage_r;

    always_comb begin
      dvs       = NUM_W'(st[i].len) << B;
      stage_nxt = st[i];
      for (int k = 0; k < AXES; k++) begin
        if (st[i].rem[k] >= dvs) begin
          stage_nxt.rem[k] = st[i].rem[k] - dvs;
          stage_nxt.quo[k] = st[i].quo[k] | (QUO_W'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (adv) begin
        stage_r <= stage_nxt;
      end
    end

    assign st[i+1] = stage_r;
  end

  assign dout = st[QUO_W];

endmodule

`default_nettype wire

/* sim/triangle_face_normal_top_tb.sv */
// testbench for triangle_face_normal_top: vertex loads and triangle normals with
// random idling on both channels, checked against an in-bench fixed-point predictor
// depends on tfn_pkg and triangle_face_normal_top
`timescale 1ns / 100ps
`default_nettype none

module triangle_face_normal_top_tb;
  import tfn_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_ITEMS   = 620;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tfn_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tfn_out_t out_data;

  logic signed [POS_W-1:0] vertex_pos [1024][AXES];
  int       loaded_slots[$];
  bit       slot_loaded [1024];
  tfn_out_t expected_normals[$];
  int       error_count;
  int       quiet;
  int       idle_cycles;
  int       n_loads;
  int       n_triangles;
  int       n_degenerate;
  int       n_checked;

  triangle_face_normal_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x   = x - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic tfn_out_t face_normal(tfn_in_t t);
    tfn_out_t        r;
    longint          pa[AXES], pb[AXES], pc[AXES], e1[AXES], e2[AXES], cr[AXES];
    longint unsigned mag[AXES], mx, s, len, q;
    longint          nv[AXES];
    for (int k = 0; k < AXES; k++) begin
      pa[k] = vertex_pos[t.corner_a][k];
      pb[k] = vertex_pos[t.corner_b][k];
      pc[k] = vertex_pos[t.corner_c][k];
      e1[k] = pc[k] - pa[k];
      e2[k] = pb[k] - pa[k];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (int k = 0; k < AXES; k++) begin
      mag[k] = (cr[k] < 0) ? -cr[k] : cr[k];
      if (mag[k] > mx) mx = mag[k];
    end
    r.out_a      = t.corner_a;
    r.out_b      = t.corner_b;
    r.out_c      = t.corner_c;
    r.degenerate = (mx == 0);
    for (int k = 0; k < AXES; k++) nv[k] = 0;
    if (mx != 0) begin
      // common truncating shift until the largest magnitude fits 24 bits
      while (mx >= (64'd1 << 24)) begin
        mx = mx >> 1;
        for (int k = 0; k < AXES; k++) mag[k] = mag[k] >> 1;
      end
      s = 0;
      for (int k = 0; k < AXES; k++) s = s + mag[k] * mag[k];
      len = int_sqrt(s << 12);
      for (int k = 0; k < AXES; k++) begin
        q = ((mag[k] << 20) + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        nv[k] = (cr[k] < 0) ? -longint'(q) : longint'(q);
      end
    end
    r.norm_x = nv[0][NORM_W-1:0];
    r.norm_y = nv[1][NORM_W-1:0];
    r.norm_z = nv[2][NORM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_coord();
    logic [POS_W-1:0] v;
    int               w;
    v = POS_W'($urandom);
    w = $urandom_range(1, POS_W);
    return $signed(v) >>> (POS_W - w);
  endfunction

  // present one item, hold it until accepted, then update the predictor
  task automatic send_item(tfn_in_t item);
    if (quiet == 0 && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 40) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.command == CMD_LOAD) begin
      vertex_pos[item.vertex_index][0] = item.pos_x;
      vertex_pos[item.vertex_index][1] = item.pos_y;
      vertex_pos[item.vertex_index][2] = item.pos_z;
      if (!slot_loaded[item.vertex_index]) loaded_slots.push_back(item.vertex_index);
      slot_loaded[item.vertex_index] = 1'b1;
      n_loads++;
    end else begin
      expected_normals.push_back(face_normal(item));
      n_triangles++;
    end
  endtask

  task automatic load_vertex(int idx, logic signed [POS_W-1:0] x, y, z);
    tfn_in_t     t;
    logic [95:0] rnd;
    rnd            = {$urandom, $urandom, $urandom};
    t              = rnd[$bits(tfn_in_t)-1:0];
    t.command      = CMD_LOAD;
    t.vertex_index = IDX_W'(idx);
    t.pos_x        = x;
    t.pos_y        = y;
    t.pos_z        = z;
    send_item(t);
  endtask

  task automatic triangle(int a, b, c);
    tfn_in_t     t;
    logic [95:0] rnd;
    rnd            = {$urandom, $urandom, $urandom};
    t              = rnd[$bits(tfn_in_t)-1:0];
    t.command      = CMD_TRI;
    t.corner_a     = IDX_W'(a);
    t.corner_b     = IDX_W'(b);
    t.corner_c     = IDX_W'(c);
    send_item(t);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    load_vertex(0, 16'sd0, 16'sd0, 16'sd0);
    load_vertex(1, 16'sd256, 16'sd0, 16'sd0);
    load_vertex(2, 16'sd0, 16'sd256, 16'sd0);
    load_vertex(1023, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    load_vertex(512, -16'sh8000, 16'sh7fff, -16'sh8000);
    load_vertex(341, 16'sh7fff, -16'sh8000, 16'sh7fff);
    load_vertex(682, 16'sd512, 16'sd0, 16'sd0);
    triangle(0, 1, 2);
    triangle(0, 2, 1);
    triangle(1023, 512, 341);
    triangle(341, 512, 1023);
    // collinear and repeated corners give a zero cross
    triangle(0, 1, 682);
    triangle(1023, 1023, 1023);
    triangle(0, 0, 2);
    load_vertex(3, -16'sh8000, -16'sh8000, -16'sh8000);
    triangle(3, 1023, 512);
    triangle(3, 0, 1);
    load_vertex(4, 16'sd0, 16'sd0, 16'sd1);
    load_vertex(5, 16'sd1, 16'sd0, 16'sd0);
    triangle(0, 4, 5);
  endtask

  task automatic test_random(int count);
    int pick[3];
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) quiet = 1;
      if (i == count / 2) quiet = 0;
      if (loaded_slots.size() < 3 || $urandom_range(99) < 40) begin
        load_vertex($urandom_range(1023), rand_coord(), rand_coord(), rand_coord());
      end else begin
        for (int k = 0; k < 3; k++)
          pick[k] = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
        triangle(pick[0], pick[1], pick[2]);
      end
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    tfn_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        exp_r = expected_normals.pop_front();
        n_checked++;
        if (exp_r.degenerate) n_degenerate++;
        if (out_data.out_a !== exp_r.out_a || out_data.out_b !== exp_r.out_b ||
            out_data.out_c !== exp_r.out_c) begin
          $display("%0t: corner mismatch expected %0d %0d %0d actual %0d %0d %0d", $time,
                   exp_r.out_a, exp_r.out_b, exp_r.out_c,
                   out_data.out_a, out_data.out_b, out_data.out_c);
          error_count++;
        end
        if (out_data.norm_x !== exp_r.norm_x || out_data.norm_y !== exp_r.norm_y ||
            out_data.norm_z !== exp_r.norm_z) begin
          $display("%0t: normal mismatch expected %0d %0d %0d actual %0d %0d %0d", $time,
                   exp_r.norm_x, exp_r.norm_y, exp_r.norm_z,
                   out_data.norm_x, out_data.norm_y, out_data.norm_z);
          error_count++;
        end
        if (out_data.degenerate !== exp_r.degenerate) begin
          $display("%0t: degenerate mismatch expected %b actual %b", $time,
                   exp_r.degenerate, out_data.degenerate);
          error_count++;
        end
      end
    end
    out_stall <= (quiet == 0) && ($urandom_range(99) < 12);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    error_count  = 0;
    quiet        = 0;
    n_loads      = 0;
    n_triangles  = 0;
    n_degenerate = 0;
    n_checked    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_results_drained();
    test_random(RANDOM_ITEMS);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d vertex loads and %0d triangles, %0d normals checked (%0d degenerate)",
             n_loads, n_triangles, n_checked, n_degenerate);
    if (error_count == 0 && expected_normals.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
